[rtl/bgi_pkg.sv]
// Shared types and constants of the bilinear grid interpolator.
package bgi_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic signed [32:0] ONE_Q16  = 33'sd65536;
    localparam logic signed [49:0] FRAC_LIM = 50'sd1073741824;
    localparam logic signed [69:0] SAT_MAX  = 70'sd2147483647;
    localparam logic signed [69:0] SAT_MIN  = -70'sd2147483648;
    localparam logic signed [101:0] RND_HALF = 102'sd2147483648;

    typedef enum logic [2:0] {
        REG_X_ORIGIN     = 3'd0,
        REG_Y_ORIGIN     = 3'd1,
        REG_X_INV_STEP   = 3'd2,
        REG_Y_INV_STEP   = 3'd3,
        REG_COLUMNS_USED = 3'd4,
        REG_ROWS_USED    = 3'd5
    } cfg_addr_t;

    typedef struct packed {
        logic signed [31:0] x_origin;
        logic signed [31:0] y_origin;
        logic [31:0]        x_inv_step;
        logic [31:0]        y_inv_step;
        logic [7:0]         columns_used;
        logic [7:0]         rows_used;
    } cfg_t;

    typedef struct packed {
        logic [6:0]         cell_col;
        logic [6:0]         cell_row;
        logic               col_lsb;
        logic               row_lsb;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
    } qmeta_t;

endpackage

[rtl/bgi_in_if.sv]
// Request channel: sample writes and point queries.
interface bgi_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [6:0]         grid_col;
    logic [6:0]         grid_row;
    logic signed [31:0] sample_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;

    modport source (output valid, operation, grid_col, grid_row, sample_value, query_x,
                    query_y, input ready);
    modport sink (input valid, operation, grid_col, grid_row, sample_value, query_x,
                  query_y, output ready);
endinterface

[rtl/bgi_out_if.sv]
// Result channel: interpolated value and cell corner.
interface bgi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] interp_value;
    logic [6:0]         cell_col;
    logic [6:0]         cell_row;

    modport source (output valid, interp_value, cell_col, cell_row, input ready);
    modport sink (input valid, interp_value, cell_col, cell_row, output ready);
endinterface

[rtl/bgi_ram.sv]
// Generic simple dual-port RAM with registered read.
module bgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[rtl/bgi_front.sv]
// Front pipeline: origin offset, reciprocal scaling and cell location.
module bgi_front
    import bgi_pkg::*;
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 128,
    localparam int CB = $clog2(MAX_COLS),
    localparam int RB = $clog2(MAX_ROWS)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg,
    bgi_in_if.sink         request,
    input  logic           take,
    output logic           s3_valid,
    output logic           s3_query,
    output logic [6:0]     s3_wcol,
    output logic [6:0]     s3_wrow,
    output logic [31:0]    s3_wdata,
    output logic [CB-1:0]  s3_kcol,
    output logic [RB-1:0]  s3_krow,
    output qmeta_t         s3_meta
);
    // corner index and clamped fraction from a scaled product
    function automatic logic [44:0] locate(input logic signed [65:0] prod,
                                           input logic [7:0] used,
                                           input logic [12:0] maxn);
        logic signed [49:0] u;
        logic [12:0]        n;
        logic [12:0]        lim;
        logic [33:0]        uk;
        logic [12:0]        k;
        logic signed [49:0] f;
        u   = prod[65:16];
        n   = (13'(used) < 13'd2) ? 13'd2 : ((13'(used) > maxn) ? maxn : 13'(used));
        lim = n - 13'd2;
        uk  = u[49:16];
        k   = '0;
        if (!u[49])
        begin
            k = (uk > 34'(lim)) ? lim : 13'(uk);
        end
        f = u - $signed({21'b0, k, 16'b0});
        if (f > FRAC_LIM)
        begin
            f = FRAC_LIM;
        end
        else if (f < -FRAC_LIM)
        begin
            f = -FRAC_LIM;
        end
        return {k, 32'(f)};
    endfunction

    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;
    logic op1_reg, op2_reg, op3_reg;
    logic [6:0] wcol1_reg, wcol2_reg, wcol3_reg;
    logic [6:0] wrow1_reg, wrow2_reg, wrow3_reg;
    logic [31:0] wdata1_reg, wdata2_reg, wdata3_reg;
    logic signed [32:0] dx1_reg, dy1_reg, dx_next, dy_next;
    logic signed [65:0] px2_reg, py2_reg, px_next, py_next;
    logic [44:0] locx, locy;
    logic [CB-1:0] kcol3_reg;
    logic [RB-1:0] krow3_reg;
    logic signed [31:0] fx3_reg, fy3_reg;

    assign en3 = !v3_reg || take;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign request.ready = en1;

    assign dx_next = 33'(request.query_x) - 33'(cfg.x_origin);
    assign dy_next = 33'(request.query_y) - 33'(cfg.y_origin);
    assign px_next = dx1_reg * $signed({1'b0, cfg.x_inv_step});
    assign py_next = dy1_reg * $signed({1'b0, cfg.y_inv_step});
    assign locx    = locate(px2_reg, cfg.columns_used, 13'(MAX_COLS));
    assign locy    = locate(py2_reg, cfg.rows_used, 13'(MAX_ROWS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= request.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            op1_reg    <= request.operation;
            wcol1_reg  <= request.grid_col;
            wrow1_reg  <= request.grid_row;
            wdata1_reg <= request.sample_value;
            dx1_reg    <= dx_next;
            dy1_reg    <= dy_next;
        end
        if (en2)
        begin
            op2_reg    <= op1_reg;
            wcol2_reg  <= wcol1_reg;
            wrow2_reg  <= wrow1_reg;
            wdata2_reg <= wdata1_reg;
            px2_reg    <= px_next;
            py2_reg    <= py_next;
        end
        if (en3)
        begin
            op3_reg    <= op2_reg;
            wcol3_reg  <= wcol2_reg;
            wrow3_reg  <= wrow2_reg;
            wdata3_reg <= wdata2_reg;
            kcol3_reg  <= CB'(locx[44:32]);
            krow3_reg  <= RB'(locy[44:32]);
            fx3_reg    <= locx[31:0];
            fy3_reg    <= locy[31:0];
        end
    end

    assign s3_valid         = v3_reg;
    assign s3_query         = (op3_reg == OP_QUERY);
    assign s3_wcol          = wcol3_reg;
    assign s3_wrow          = wrow3_reg;
    assign s3_wdata         = wdata3_reg;
    assign s3_kcol          = kcol3_reg;
    assign s3_krow          = krow3_reg;
    assign s3_meta.cell_col = 7'(kcol3_reg);
    assign s3_meta.cell_row = 7'(krow3_reg);
    assign s3_meta.col_lsb  = kcol3_reg[0];
    assign s3_meta.row_lsb  = krow3_reg[0];
    assign s3_meta.fx       = fx3_reg;
    assign s3_meta.fy       = fy3_reg;
endmodule

[rtl/bgi_blend.sv]
// Blend pipeline: weights, corner products, exact sum, rounding and saturation.
module bgi_blend
    import bgi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  qmeta_t      in_meta,
    input  logic [31:0] bank_data [4],
    bgi_out_if.source   result
);
    logic en4, en5, en6, en7, en8, en9, en_out;
    logic v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg, vo_reg;
    qmeta_t m4_reg;
    logic [6:0] col5_reg, col6_reg, col7_reg, col8_reg, col9_reg, colo_reg;
    logic [6:0] row5_reg, row6_reg, row7_reg, row8_reg, row9_reg, rowo_reg;
    logic signed [31:0] z00, z01, z10, z11;
    logic signed [32:0] wx0, wx1;
    logic signed [64:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [32:0] wy0_5_reg, wy1_5_reg, wy0_6_reg, wy1_6_reg;
    logic signed [65:0] h0_reg, h1_reg;
    logic signed [66:0] lo0_reg, lo1_reg;
    logic signed [65:0] hi0_reg, hi1_reg;
    logic signed [67:0] losum_reg;
    logic signed [66:0] hisum_reg;
    logic signed [101:0] acc_next;
    logic signed [69:0] rnd_reg;
    logic signed [31:0] val_next, val_reg;

    assign en_out   = !vo_reg || result.ready;
    assign en9      = !v9_reg || en_out;
    assign en8      = !v8_reg || en9;
    assign en7      = !v7_reg || en8;
    assign en6      = !v6_reg || en7;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign in_ready = en4;

    // corner (R,C) sits in bank {row_lsb^R, col_lsb^C}
    assign z00 = $signed(bank_data[{m4_reg.row_lsb, m4_reg.col_lsb}]);
    assign z01 = $signed(bank_data[{m4_reg.row_lsb, !m4_reg.col_lsb}]);
    assign z10 = $signed(bank_data[{!m4_reg.row_lsb, m4_reg.col_lsb}]);
    assign z11 = $signed(bank_data[{!m4_reg.row_lsb, !m4_reg.col_lsb}]);
    assign wx0 = ONE_Q16 - 33'(m4_reg.fx);
    assign wx1 = 33'(m4_reg.fx);

    assign acc_next = (102'(hisum_reg) <<< 33) + 102'(losum_reg) + RND_HALF;

    always_comb
    begin
        if (rnd_reg > SAT_MAX)
        begin
            val_next = 32'(SAT_MAX);
        end
        else if (rnd_reg < SAT_MIN)
        begin
            val_next = 32'(SAT_MIN);
        end
        else
        begin
            val_next = 32'(rnd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en4)    v4_reg <= in_valid;
            if (en5)    v5_reg <= v4_reg;
            if (en6)    v6_reg <= v5_reg;
            if (en7)    v7_reg <= v6_reg;
            if (en8)    v8_reg <= v7_reg;
            if (en9)    v9_reg <= v8_reg;
            if (en_out) vo_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            m4_reg <= in_meta;
        end
        if (en5)
        begin
            p00_reg   <= wx0 * z00;
            p01_reg   <= wx1 * z01;
            p10_reg   <= wx0 * z10;
            p11_reg   <= wx1 * z11;
            wy0_5_reg <= ONE_Q16 - 33'(m4_reg.fy);
            wy1_5_reg <= 33'(m4_reg.fy);
            col5_reg  <= m4_reg.cell_col;
            row5_reg  <= m4_reg.cell_row;
        end
        if (en6)
        begin
            h0_reg    <= 66'(p00_reg) + 66'(p01_reg);
            h1_reg    <= 66'(p10_reg) + 66'(p11_reg);
            wy0_6_reg <= wy0_5_reg;
            wy1_6_reg <= wy1_5_reg;
            col6_reg  <= col5_reg;
            row6_reg  <= row5_reg;
        end
        if (en7)
        begin
            lo0_reg  <= $signed({1'b0, h0_reg[32:0]}) * wy0_6_reg;
            lo1_reg  <= $signed({1'b0, h1_reg[32:0]}) * wy1_6_reg;
            hi0_reg  <= $signed(h0_reg[65:33]) * wy0_6_reg;
            hi1_reg  <= $signed(h1_reg[65:33]) * wy1_6_reg;
            col7_reg <= col6_reg;
            row7_reg <= row6_reg;
        end
        if (en8)
        begin
            losum_reg <= 68'(lo0_reg) + 68'(lo1_reg);
            hisum_reg <= 67'(hi0_reg) + 67'(hi1_reg);
            col8_reg  <= col7_reg;
            row8_reg  <= row7_reg;
        end
        if (en9)
        begin
            rnd_reg  <= acc_next[101:32];
            col9_reg <= col8_reg;
            row9_reg <= row8_reg;
        end
        if (en_out)
        begin
            val_reg  <= val_next;
            colo_reg <= col9_reg;
            rowo_reg <= row9_reg;
        end
    end

    assign result.valid        = vo_reg;
    assign result.interp_value = val_reg;
    assign result.cell_col     = colo_reg;
    assign result.cell_row     = rowo_reg;
endmodule

[rtl/bilinear_grid_interpolator_core.sv]
// Top level of the bilinear grid interpolator: register file, banked grid store, pipelines.
//
//  channel   | dir | handshake           | payload
//  ----------+-----+---------------------+-------------------------------------------
//  request   | in  | valid / ready       | operation, grid_col, grid_row, sample_value,
//            |     |                     | query_x, query_y
//  result    | out | valid / ready       | interp_value, cell_col, cell_row
//  apb       | in  | psel/penable/pready | paddr, pwrite, pwdata, prdata
//
// One item is taken every cycle unless the pipeline is stalled. A query's result passes
// the front and blend stages; a sample write gives none. The grid sits in four banks chosen
// by row and column parity, so the four corners of a cell are read together through one
// read port each. Reset clears the pipeline valid bits and loads the configuration
// register defaults; the grid store needs no clearing pass. A stalled result holds the
// output register, and earlier stages keep filling bubbles until they meet it.
module bilinear_grid_interpolator_core
    import bgi_pkg::*;
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    bgi_in_if.sink      request,
    bgi_out_if.source   result
);
    localparam int CB    = $clog2(MAX_COLS);
    localparam int RB    = $clog2(MAX_ROWS);
    localparam int CHB   = (CB > 1) ? CB - 1 : 1;
    localparam int RHB   = (RB > 1) ? RB - 1 : 1;
    localparam int BANK_DEPTH = 1 << (CHB + RHB);

    // ---------------- configuration registers ----------------
    logic signed [31:0] x_origin_reg, y_origin_reg;
    logic [31:0]        x_inv_step_reg, y_inv_step_reg;
    logic [7:0]         columns_used_reg, rows_used_reg;
    logic               cfg_wr;
    cfg_addr_t          cfg_sel;
    cfg_t               cfg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = cfg_addr_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg     <= '0;
            y_origin_reg     <= '0;
            x_inv_step_reg   <= 32'd65536;
            y_inv_step_reg   <= 32'd65536;
            columns_used_reg <= 8'd128;
            rows_used_reg    <= 8'd128;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_X_ORIGIN:     x_origin_reg     <= pwdata;
                REG_Y_ORIGIN:     y_origin_reg     <= pwdata;
                REG_X_INV_STEP:   x_inv_step_reg   <= pwdata;
                REG_Y_INV_STEP:   y_inv_step_reg   <= pwdata;
                REG_COLUMNS_USED: columns_used_reg <= pwdata[7:0];
                REG_ROWS_USED:    rows_used_reg    <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_X_ORIGIN:     prdata = x_origin_reg;
            REG_Y_ORIGIN:     prdata = y_origin_reg;
            REG_X_INV_STEP:   prdata = x_inv_step_reg;
            REG_Y_INV_STEP:   prdata = y_inv_step_reg;
            REG_COLUMNS_USED: prdata = 32'(columns_used_reg);
            REG_ROWS_USED:    prdata = 32'(rows_used_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.x_origin     = x_origin_reg;
    assign cfg.y_origin     = y_origin_reg;
    assign cfg.x_inv_step   = x_inv_step_reg;
    assign cfg.y_inv_step   = y_inv_step_reg;
    assign cfg.columns_used = columns_used_reg;
    assign cfg.rows_used    = rows_used_reg;

    // ---------------- front pipeline ----------------
    logic          s3_valid, s3_query, take;
    logic [6:0]    s3_wcol, s3_wrow;
    logic [31:0]   s3_wdata;
    logic [CB-1:0] s3_kcol;
    logic [RB-1:0] s3_krow;
    qmeta_t        s3_meta;

    bgi_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .request  (request),
        .take     (take),
        .s3_valid (s3_valid),
        .s3_query (s3_query),
        .s3_wcol  (s3_wcol),
        .s3_wrow  (s3_wrow),
        .s3_wdata (s3_wdata),
        .s3_kcol  (s3_kcol),
        .s3_krow  (s3_krow),
        .s3_meta  (s3_meta)
    );

    // ---------------- banked grid store ----------------
    // Writes and corner reads are both issued from stage three, so items
    // touch the store strictly in order and no forwarding is needed.
    logic                 wr_in_range;
    logic                 ram_re;
    logic [3:0]           bank_we;
    logic [RHB+CHB-1:0]   waddr;
    logic [RHB+CHB-1:0]   raddr [4];
    logic [31:0]          bank_data [4];

    assign wr_in_range = (32'(s3_wcol) < MAX_COLS) && (32'(s3_wrow) < MAX_ROWS);
    assign ram_re      = s3_valid && s3_query && take;
    assign waddr       = {RHB'(s3_wrow >> 1), CHB'(s3_wcol >> 1)};

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic [1:0] BANK_ID = 2'(b);
        logic [RB-1:0] rsel;
        logic [CB-1:0] csel;

        // pick whichever of the two corner rows/columns has this bank's parity
        assign rsel = (s3_krow[0] == BANK_ID[1]) ? s3_krow : s3_krow + RB'(1);
        assign csel = (s3_kcol[0] == BANK_ID[0]) ? s3_kcol : s3_kcol + CB'(1);
        assign raddr[b] = {RHB'(rsel >> 1), CHB'(csel >> 1)};
        assign bank_we[b] = s3_valid && !s3_query && take && wr_in_range &&
                            (s3_wrow[0] == BANK_ID[1]) && (s3_wcol[0] == BANK_ID[0]);

        bgi_ram #(
            .WIDTH (32),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (waddr),
            .wdata (s3_wdata),
            .re    (ram_re),
            .raddr (raddr[b]),
            .rdata (bank_data[b])
        );
    end

    // ---------------- blend pipeline ----------------
    bgi_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid && s3_query),
        .in_ready  (take),
        .in_meta   (s3_meta),
        .bank_data (bank_data),
        .result    (result)
    );

    // ---------------- checks ----------------
    a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !((|bank_we) && ram_re))
        else $error("grid store read and write issued together");

    a_one_bank: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(bank_we))
        else $error("sample write hit more than one bank");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> request.ready)
        else $error("request stalled with empty output register");
endmodule
